>>> src/hsl_to_rgb_converter_core_assert.svh
// assertion macros shared by the hsl to rgb converter core and its divider
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HSLC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hslc: check failed");

// next-cycle implication, sampled on clk, off during rst
`define HSLC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hslc: check failed");

`endif

>>> src/hslc_pkg.sv
// shared types and constants of the hsl to rgb converter
`timescale 1ns / 1ps

package hslc_pkg;

  // fixed field widths
  localparam int HUE_IN_W   = 13;
  localparam int LEVEL_IN_W = 16;
  localparam int CHAN_W     = 8;

  // hue geometry in whole degrees
  localparam int SECTOR_DEG   = 60;
  localparam int FULL_DEG     = 360;
  localparam int SECTOR_COUNT = 6;
  // odd factor of a sector: 60 = 15 * 4
  localparam int SECTOR_ODD   = 15;

  // hue sector, named after the colour it starts at
  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

endpackage

>>> src/hslc_hsl_if.sv
// handshake channel carrying one hsl word
`timescale 1ns / 1ps

interface hslc_hsl_if;
  import hslc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HUE_IN_W-1:0]   hue_sixteenths;
  logic [LEVEL_IN_W-1:0] saturation;
  logic [LEVEL_IN_W-1:0] lightness;

  modport source (output valid, output hue_sixteenths, output saturation,
                  output lightness, input ready);
  modport sink (input valid, input hue_sixteenths, input saturation,
                input lightness, output ready);
endinterface

>>> src/hslc_rgb_if.sv
// handshake channel carrying one rgb word
`timescale 1ns / 1ps

interface hslc_rgb_if;
  import hslc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/hslc_front.sv
// front stages: clamping, hue sector split, lightness span and chroma
`timescale 1ns / 1ps

module hslc_front #(
  parameter int HUE_FRAC_BITS   = 4,
  parameter int LEVEL_FRAC_BITS = 15,
  localparam int LV_W = LEVEL_FRAC_BITS + 1,
  localparam int W_W  = $clog2((hslc_pkg::SECTOR_DEG << HUE_FRAC_BITS) + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hslc_pkg::HUE_IN_W-1:0]    hue,
  input  logic [hslc_pkg::LEVEL_IN_W-1:0]  sat,
  input  logic [hslc_pkg::LEVEL_IN_W-1:0]  lit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [LV_W-1:0]                  chroma,
  output logic [W_W-1:0]                   weight,
  output hslc_pkg::sector_t                sector,
  output logic [LV_W-1:0]                  level,
  output logic                             black
);
  import hslc_pkg::*;

  localparam logic [31:0] PER  = 32'(SECTOR_DEG) << HUE_FRAC_BITS;
  localparam logic [31:0] FULL = 32'(FULL_DEG) << HUE_FRAC_BITS;
  localparam logic [31:0] ONE  = 32'(1) << LEVEL_FRAC_BITS;
  localparam int R_W = $clog2(SECTOR_DEG << HUE_FRAC_BITS);
  localparam logic [LV_W:0] ONE_X = (LV_W + 1)'(1) << LEVEL_FRAC_BITS;

  // stage 1 combinational
  logic [31:0]     hue_x;
  logic [31:0]     sat_x;
  logic [31:0]     lit_x;
  logic [31:0]     base;
  logic [2:0]      idx;
  logic            black_c;
  logic [LV_W-1:0] sat_c;
  logic [LV_W-1:0] lit_c;
  logic [LV_W:0]   lit2;
  logic [LV_W:0]   lit_dev;
  logic [LV_W-1:0] span_c;
  sector_t         sect_c;
  logic [R_W-1:0]  rem_c;

  // stage 1 registers
  logic            v1;
  logic            en1;
  sector_t         sect1;
  logic [R_W-1:0]  rem1;
  logic [LV_W-1:0] span1;
  logic [LV_W-1:0] sat1;
  logic [LV_W-1:0] lit1;
  logic            black1;

  // stage 2 combinational
  logic            en2;
  logic [2*LV_W-1:0] prod_c;
  logic [LV_W-1:0] chroma_c;
  logic [W_W-1:0]  weight_c;

  // stage enables: a stage moves when it is empty or its successor moves
  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // clamp, sector split and lightness span
  always_comb begin
    hue_x   = 32'(hue);
    sat_x   = 32'(sat);
    lit_x   = 32'(lit);
    black_c = hue_x > FULL;
    sat_c   = (sat_x > ONE) ? LV_W'(ONE) : LV_W'(sat_x);
    lit_c   = (lit_x > ONE) ? LV_W'(ONE) : LV_W'(lit_x);
    idx     = 3'd0;
    base    = 32'd0;
    for (int j = 1; j <= SECTOR_COUNT; j++) begin
      if (hue_x >= 32'(j) * PER) begin
        idx  = 3'(j);
        base = 32'(j) * PER;
      end
    end
    // a full turn wraps to the red sector with no remainder
    sect_c  = (idx == 3'(SECTOR_COUNT)) ? SECT_RED : sector_t'(idx);
    rem_c   = R_W'(hue_x - base);
    lit2    = {lit_c, 1'b0};
    lit_dev = (lit2 >= ONE_X) ? (lit2 - ONE_X) : (ONE_X - lit2);
    span_c  = LV_W'(ONE_X - lit_dev);
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en1) begin
      sect1  <= sect_c;
      rem1   <= rem_c;
      span1  <= span_c;
      sat1   <= sat_c;
      lit1   <= lit_c;
      black1 <= black_c;
    end
  end

  // chroma and secondary weight
  always_comb begin
    prod_c   = (2*LV_W)'(span1) * (2*LV_W)'(sat1);
    chroma_c = prod_c[LEVEL_FRAC_BITS +: LV_W];
    // odd sectors fall from full weight, even sectors rise from zero
    weight_c = sect1[0] ? (W_W'(PER) - W_W'(rem1)) : W_W'(rem1);
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en2) begin
      chroma <= chroma_c;
      weight <= weight_c;
      sector <= sect1;
      level  <= lit1;
      black  <= black1;
    end
  end

endmodule

>>> src/hslc_div.sv
// secondary component: chroma times weight over one sector, then doubled levels
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_core_assert.svh"

module hslc_div #(
  parameter int HUE_FRAC_BITS   = 4,
  parameter int LEVEL_FRAC_BITS = 15,
  localparam int LV_W = LEVEL_FRAC_BITS + 1,
  localparam int W_W  = $clog2((hslc_pkg::SECTOR_DEG << HUE_FRAC_BITS) + 1),
  localparam int V_W  = LEVEL_FRAC_BITS + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LV_W-1:0]   chroma,
  input  logic [W_W-1:0]    weight,
  input  hslc_pkg::sector_t sector,
  input  logic [LV_W-1:0]   level,
  input  logic              black,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [V_W-1:0]    vc2,
  output logic [V_W-1:0]    vx2,
  output logic [V_W-1:0]    m2,
  output hslc_pkg::sector_t sector_out,
  output logic              black_out
);
  import hslc_pkg::*;

  localparam int P_W = LV_W + W_W;
  // quotient input after the power-of-two part of a sector is shifted out
  localparam int A_W = LV_W + 4;
  localparam logic [A_W-1:0] RECIP = A_W'((64'(1) << A_W) / 64'(SECTOR_ODD));
  localparam logic [A_W-1:0] ODD_A = A_W'(SECTOR_ODD);

  logic en3;
  logic en4;
  logic en5;

  // stage 3
  logic            v3;
  logic [P_W-1:0]  prod3;
  logic [V_W-1:0]  m2_3;
  logic [LV_W-1:0] chroma3;
  sector_t         sect3;
  logic            black3;

  // stage 4
  logic              v4;
  logic [A_W-1:0]    a_c;
  logic [2*A_W-1:0]  qp_c;
  logic [A_W-1:0]    a4;
  logic [LV_W-1:0]   q4;
  logic [V_W-1:0]    m2_4;
  logic [LV_W-1:0]   chroma4;
  sector_t           sect4;
  logic              black4;

  // stage 5 combinational
  logic [A_W-1:0]  q15_c;
  logic [A_W-1:0]  rem_c;
  logic [LV_W-1:0] second_c;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) begin
        v3 <= in_valid;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        out_valid <= v4;
      end
    end
  end

  // stage 3: weighted chroma and doubled offset
  always_ff @(posedge clk) begin
    if (en3) begin
      prod3   <= P_W'(chroma) * P_W'(weight);
      m2_3    <= V_W'({level, 1'b0}) - V_W'(chroma);
      chroma3 <= chroma;
      sect3   <= sector;
      black3  <= black;
    end
  end

  // stage 4: estimate quotient by the odd factor with a reciprocal
  always_comb begin
    a_c  = prod3[HUE_FRAC_BITS + 2 +: A_W];
    qp_c = (2*A_W)'(a_c) * (2*A_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      a4      <= a_c;
      q4      <= qp_c[A_W +: LV_W];
      m2_4    <= m2_3;
      chroma4 <= chroma3;
      sect4   <= sect3;
      black4  <= black3;
    end
  end

  // stage 5: one correction step, then doubled channel levels
  always_comb begin
    q15_c    = A_W'({q4, 4'd0}) - A_W'(q4);
    rem_c    = a4 - q15_c;
    second_c = (rem_c >= ODD_A) ? (q4 + LV_W'(1)) : q4;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      vc2        <= m2_4 + V_W'({chroma4, 1'b0});
      vx2        <= m2_4 + V_W'({second_c, 1'b0});
      m2         <= m2_4;
      sector_out <= sect4;
      black_out  <= black4;
    end
  end

  // the reciprocal estimate is never more than one below the quotient
  `HSLC_ASSERT_IMP(a_quot_close, v4, rem_c < (ODD_A + ODD_A))
  // offset, secondary and primary levels are ordered for a real hue
  `HSLC_ASSERT_IMP(a_level_order, out_valid && !black_out, (m2 <= vx2) && (vx2 <= vc2))
  // a held word keeps its levels while the next stage is blocked
  `HSLC_ASSERT_NXT(a_hold_levels, out_valid && !out_ready,
                   out_valid && $stable(vc2) && $stable(vx2) && $stable(m2))

endmodule

>>> src/hsl_to_rgb_converter_core.sv
// HSL to RGB converter: one pixel per clock while rgb.ready is high, through a six-stage
// pipeline. A word taken on hsl passes each stage register in turn to rgb; every stage holds
// its own valid bit and moves when it is empty or its successor moves, so hsl.ready stays high
// while any stage is free, and the sustained rate is one word per clock. The stages are: clamp
// and sector split, chroma multiply, weighted chroma multiply, reciprocal quotient, correction
// and doubled levels, and scaling to 8 bits with channel placement in the output register.
// A hue above a full turn gives black; saturation and lightness above 1.0 are clamped.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl_to_rgb_converter_core #(
  parameter int HUE_FRAC_BITS   = 4,
  parameter int LEVEL_FRAC_BITS = 15
) (
  input logic         clk,
  input logic         rst,
  hslc_hsl_if.sink    hsl,
  hslc_rgb_if.source  rgb
);
  import hslc_pkg::*;

  localparam int LV_W = LEVEL_FRAC_BITS + 1;
  localparam int W_W  = $clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1);
  localparam int V_W  = LEVEL_FRAC_BITS + 2;

  // front to divider
  logic            f_valid;
  logic            f_ready;
  logic [LV_W-1:0] f_chroma;
  logic [W_W-1:0]  f_weight;
  sector_t         f_sector;
  logic [LV_W-1:0] f_level;
  logic            f_black;

  // divider to output stage
  logic           d_valid;
  logic           d_ready;
  logic [V_W-1:0] d_vc2;
  logic [V_W-1:0] d_vx2;
  logic [V_W-1:0] d_m2;
  sector_t        d_sector;
  logic           d_black;

  // output stage
  logic              out_valid;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] bc;
  logic [CHAN_W-1:0] bx;
  logic [CHAN_W-1:0] bm;
  logic [CHAN_W-1:0] red_c;
  logic [CHAN_W-1:0] green_c;
  logic [CHAN_W-1:0] blue_c;

  // scale a doubled level by 255 over two, truncating
  function automatic logic [CHAN_W-1:0] to_byte(input logic [V_W-1:0] v);
    logic [V_W+7:0] sc;
    logic [8:0]     b9;
    sc = {v, 8'd0} - (V_W + 8)'(v);
    b9 = sc[LEVEL_FRAC_BITS + 1 +: 9];
    return b9[8] ? 8'hFF : b9[7:0];
  endfunction

  hslc_front #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsl.valid),
    .in_ready  (hsl.ready),
    .hue       (hsl.hue_sixteenths),
    .sat       (hsl.saturation),
    .lit       (hsl.lightness),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .chroma    (f_chroma),
    .weight    (f_weight),
    .sector    (f_sector),
    .level     (f_level),
    .black     (f_black)
  );

  hslc_div #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .chroma     (f_chroma),
    .weight     (f_weight),
    .sector     (f_sector),
    .level      (f_level),
    .black      (f_black),
    .out_valid  (d_valid),
    .out_ready  (d_ready),
    .vc2        (d_vc2),
    .vx2        (d_vx2),
    .m2         (d_m2),
    .sector_out (d_sector),
    .black_out  (d_black)
  );

  assign d_ready = !out_valid || rgb.ready;

  // scale and place the three levels by sector
  always_comb begin
    bc = to_byte(d_vc2);
    bx = to_byte(d_vx2);
    bm = to_byte(d_m2);
    case (d_sector)
      SECT_RED: begin
        red_c = bc; green_c = bx; blue_c = bm;
      end
      SECT_YELLOW: begin
        red_c = bx; green_c = bc; blue_c = bm;
      end
      SECT_GREEN: begin
        red_c = bm; green_c = bc; blue_c = bx;
      end
      SECT_CYAN: begin
        red_c = bm; green_c = bx; blue_c = bc;
      end
      SECT_BLUE: begin
        red_c = bx; green_c = bm; blue_c = bc;
      end
      default: begin
        red_c = bc; green_c = bm; blue_c = bx;
      end
    endcase
    if (d_black) begin
      red_c   = '0;
      green_c = '0;
      blue_c  = '0;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= d_valid;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (d_ready) begin
      red   <= red_c;
      green <= green_c;
      blue  <= blue_c;
    end
  end

  assign rgb.valid = out_valid;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

  // a word taken from the divider shows up on the output
  `HSLC_ASSERT_NXT(a_out_follows, d_valid && d_ready, rgb.valid)
  // a hue past a full turn leaves as black
  `HSLC_ASSERT_NXT(a_black_zero, d_valid && d_ready && d_black,
                   rgb.red == '0 && rgb.green == '0 && rgb.blue == '0)
  // in the red sector red leads and blue trails
  `HSLC_ASSERT_NXT(a_red_order, d_valid && d_ready && !d_black && d_sector == SECT_RED,
                   rgb.red >= rgb.green && rgb.green >= rgb.blue)

endmodule
